/* hw/rtl/vfbs_pkg.sv */
// Package of the vector field bilinear sampler.
// Holds the shared widths, command and register codes, and stage and result types.
// No dependencies.
package vfbs_pkg;

    localparam int unsigned DIM_W      = 7;   // grid_columns / grid_rows width
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned IDX_W      = 17;  // linear entry index, wide enough for any depth
    localparam int unsigned FORCE_W    = 32;
    localparam int unsigned HOR_W      = 35;  // row blend after the shift
    localparam int unsigned VER_W      = 38;  // column blend after the shift
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;
    localparam int unsigned USED_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_command;

    typedef struct packed {
        logic valid;
        logic sample;
        logic outside;
    } t_stage_ctl;

    typedef struct packed {
        logic                       outside_grid;
        logic signed [FORCE_W-1:0]  force_y;
        logic signed [FORCE_W-1:0]  force_x;
    } t_result;

    // Clamp a grid dimension to the largest size the store was built for.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_v);
        logic [DIM_W-1:0] r;
        if (32'(v) > max_v) begin
            r = DIM_W'(max_v);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/vfbs_grid_mem.sv */
// Force grid store of the vector field bilinear sampler.
// Two copies of the grid, each split into even and odd entry banks, give four reads a cycle.
// Depends on vfbs_pkg.
module vfbs_grid_mem #(
    parameter int unsigned GRID_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [vfbs_pkg::IDX_W-1:0]     i_wr_index,
    input  logic [2*vfbs_pkg::FORCE_W-1:0] i_wr_data,
    input  logic [vfbs_pkg::IDX_W-1:0]     i_rd_top,   // upper-left entry of the cell
    input  logic [vfbs_pkg::IDX_W-1:0]     i_rd_bot,   // lower-left entry of the cell
    output logic [2*vfbs_pkg::FORCE_W-1:0] o_v00,
    output logic [2*vfbs_pkg::FORCE_W-1:0] o_v10,
    output logic [2*vfbs_pkg::FORCE_W-1:0] o_v01,
    output logic [2*vfbs_pkg::FORCE_W-1:0] o_v11
);
    import vfbs_pkg::*;

    localparam int unsigned BANK_DEPTH = (GRID_DEPTH + 1) / 2;
    localparam int unsigned BW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned DW = 2 * FORCE_W;

    logic [DW-1:0] r_top_even [BANK_DEPTH];
    logic [DW-1:0] r_top_odd  [BANK_DEPTH];
    logic [DW-1:0] r_bot_even [BANK_DEPTH];
    logic [DW-1:0] r_bot_odd  [BANK_DEPTH];

    logic [DW-1:0] r_top_even_q, r_top_odd_q, r_bot_even_q, r_bot_odd_q;
    logic          r_top_swap, r_bot_swap;

    logic [IDX_W:0]  top_plus1, bot_plus1;
    logic [BW-1:0]   top_even_addr, top_odd_addr, bot_even_addr, bot_odd_addr;
    logic [BW-1:0]   wr_addr;

    // An entry pair (i, i+1) always has one even and one odd member: the even bank
    // reads (i+1)/2 and the odd bank i/2, whichever of the two is the left one.
    always_comb begin
        top_plus1     = {1'b0, i_rd_top} + (IDX_W + 1)'(1);
        bot_plus1     = {1'b0, i_rd_bot} + (IDX_W + 1)'(1);
        top_even_addr = top_plus1[BW:1];
        top_odd_addr  = i_rd_top[BW:1];
        bot_even_addr = bot_plus1[BW:1];
        bot_odd_addr  = i_rd_bot[BW:1];
        wr_addr       = i_wr_index[BW:1];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_index[0]) begin
            r_top_even[wr_addr] <= i_wr_data;
            r_bot_even[wr_addr] <= i_wr_data;
        end
        if (i_wr_en && i_wr_index[0]) begin
            r_top_odd[wr_addr] <= i_wr_data;
            r_bot_odd[wr_addr] <= i_wr_data;
        end
        r_top_even_q <= r_top_even[top_even_addr];
        r_top_odd_q  <= r_top_odd[top_odd_addr];
        r_bot_even_q <= r_bot_even[bot_even_addr];
        r_bot_odd_q  <= r_bot_odd[bot_odd_addr];
        r_top_swap   <= i_rd_top[0];
        r_bot_swap   <= i_rd_bot[0];
    end

    assign o_v00 = r_top_swap ? r_top_odd_q  : r_top_even_q;
    assign o_v10 = r_top_swap ? r_top_even_q : r_top_odd_q;
    assign o_v01 = r_bot_swap ? r_bot_odd_q  : r_bot_even_q;
    assign o_v11 = r_bot_swap ? r_bot_even_q : r_bot_odd_q;

endmodule

/* hw/rtl/vfbs_blend.sv */
// Bilinear blend datapath of the vector field bilinear sampler.
// Row blend, a register, then column blend with saturation to 32 bits.
// Depends on vfbs_pkg.
module vfbs_blend #(
    parameter int unsigned CELL_SHIFT = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vfbs_pkg::t_stage_ctl           i_ctl,
    input  logic [CELL_SHIFT:0]            i_rx,
    input  logic [CELL_SHIFT:0]            i_ry,
    input  logic [2*vfbs_pkg::FORCE_W-1:0] i_v00,
    input  logic [2*vfbs_pkg::FORCE_W-1:0] i_v10,
    input  logic [2*vfbs_pkg::FORCE_W-1:0] i_v01,
    input  logic [2*vfbs_pkg::FORCE_W-1:0] i_v11,
    output logic                           o_push,
    output vfbs_pkg::t_result              o_result
);
    import vfbs_pkg::*;

    localparam int unsigned WW   = CELL_SHIFT + 2;
    localparam int unsigned HP_W = FORCE_W + WW + 1;
    localparam int unsigned VP_W = HOR_W + WW + 1;
    localparam logic signed [WW-1:0] WEIGHT_ONE = WW'(2 ** CELL_SHIFT);

    function automatic logic signed [HOR_W-1:0] lerp_h(
        input logic signed [FORCE_W-1:0] a0,
        input logic signed [FORCE_W-1:0] a1,
        input logic signed [WW-1:0]      w1,
        input logic signed [WW-1:0]      w0
    );
        logic signed [FORCE_W+WW-1:0] p0, p1;
        logic signed [HP_W-1:0]       s;
        p1 = a1 * w1;
        p0 = a0 * w0;
        s  = HP_W'(p1) + HP_W'(p0);
        s  = s >>> CELL_SHIFT;
        return s[HOR_W-1:0];
    endfunction

    function automatic logic signed [VER_W-1:0] lerp_v(
        input logic signed [HOR_W-1:0] a0,
        input logic signed [HOR_W-1:0] a1,
        input logic signed [WW-1:0]    w1,
        input logic signed [WW-1:0]    w0
    );
        logic signed [HOR_W+WW-1:0] p0, p1;
        logic signed [VP_W-1:0]     s;
        p1 = a1 * w1;
        p0 = a0 * w0;
        s  = VP_W'(p1) + VP_W'(p0);
        s  = s >>> CELL_SHIFT;
        return s[VER_W-1:0];
    endfunction

    function automatic logic signed [FORCE_W-1:0] sat_force(input logic signed [VER_W-1:0] v);
        logic [VER_W-FORCE_W:0] hi;
        logic [FORCE_W-1:0]     r;
        hi = v[VER_W-1:FORCE_W-1];
        if ((&hi) || !(|hi)) begin
            r = v[FORCE_W-1:0];
        end else if (v[VER_W-1]) begin
            r = {1'b1, {(FORCE_W - 1){1'b0}}};
        end else begin
            r = {1'b0, {(FORCE_W - 1){1'b1}}};
        end
        return r;
    endfunction

    t_stage_ctl               r_ctl;
    logic [CELL_SHIFT:0]      r_ry;
    logic signed [HOR_W-1:0]  r_top_x, r_bot_x, r_top_y, r_bot_y;
    logic signed [HOR_W-1:0]  n_top_x, n_bot_x, n_top_y, n_bot_y;

    logic signed [WW-1:0]     wx, omx, wy, omy;
    logic signed [VER_W-1:0]  col_x, col_y;

    // Weights may exceed one cell, so the complementary weight can go negative.
    always_comb begin
        wx      = signed'({1'b0, i_rx});
        omx     = WEIGHT_ONE - wx;
        n_top_x = lerp_h(i_v00[FORCE_W-1:0], i_v10[FORCE_W-1:0], wx, omx);
        n_bot_x = lerp_h(i_v01[FORCE_W-1:0], i_v11[FORCE_W-1:0], wx, omx);
        n_top_y = lerp_h(i_v00[2*FORCE_W-1:FORCE_W], i_v10[2*FORCE_W-1:FORCE_W], wx, omx);
        n_bot_y = lerp_h(i_v01[2*FORCE_W-1:FORCE_W], i_v11[2*FORCE_W-1:FORCE_W], wx, omx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ry    <= i_ry;
        r_top_x <= n_top_x;
        r_bot_x <= n_bot_x;
        r_top_y <= n_top_y;
        r_bot_y <= n_bot_y;
    end

    always_comb begin
        wy    = signed'({1'b0, r_ry});
        omy   = WEIGHT_ONE - wy;
        col_x = lerp_v(r_top_x, r_bot_x, wy, omy);
        col_y = lerp_v(r_top_y, r_bot_y, wy, omy);
        o_result = '0;
        if (r_ctl.sample) begin
            if (r_ctl.outside) begin
                o_result.outside_grid = 1'b1;
            end else begin
                o_result.force_x = sat_force(col_x);
                o_result.force_y = sat_force(col_y);
            end
        end
    end

    assign o_push = r_ctl.valid;

endmodule

/* hw/rtl/vfbs_out_fifo.sv */
// Result queue of the vector field bilinear sampler.
// Decouples the fixed-latency pipeline from output back-pressure.
// Depends on vfbs_pkg.
module vfbs_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vfbs_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output vfbs_pkg::t_result o_data
);
    import vfbs_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [USED_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + USED_W'(1);
                2'b01:   r_count <= r_count - USED_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

/* hw/rtl/vector_field_bilinear_sampler.sv */
// Vector field bilinear sampler: takes one command per clock cycle while s_axis_tready is
// high, loads or samples, with one result per command. The grid sits in four synchronous
// RAM banks (two copies, even and odd entries), so the four neighbours of a cell are read
// in the same cycle and a sample never waits on the store. An eight-entry result queue
// absorbs output stalls; input tready falls only while eight commands are in flight or
// queued. The grid needs no clearing after reset, but every entry a sample touches must
// have been loaded first.
// Depends on vfbs_pkg, vfbs_grid_mem, vfbs_blend and vfbs_out_fifo.
module vector_field_bilinear_sampler #(
    parameter int unsigned CELL_SHIFT  = 3,
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, load_force_x, load_force_y, pos_x, pos_y, four zero bits
    input  logic [111:0]                     s_axis_tdata,
    // command
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // force_x, force_y
    output logic [63:0]                      m_axis_tdata,
    // outside_grid
    output logic [0:0]                       m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vfbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vfbs_pkg::DIM_W-1:0]       i_cfg_data
);
    import vfbs_pkg::*;

    localparam int unsigned GRID_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned HALF       = 2 ** (CELL_SHIFT - 1);
    localparam int unsigned POS_W      = 16;
    localparam int unsigned CELL_W     = POS_W + 1;

    // Configuration
    logic [DIM_W-1:0] r_cols, r_rows;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= sat_dim(DIM_W'(64), MAX_COLUMNS);
            r_rows <= sat_dim(DIM_W'(64), MAX_ROWS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRID_COLUMNS: r_cols <= sat_dim(i_cfg_data, MAX_COLUMNS);
                REG_GRID_ROWS:    r_rows <= sat_dim(i_cfg_data, MAX_ROWS);
                default:          r_cols <= r_cols;
            endcase
        end
    end

    // Input unpacking and cell position
    logic                      accept, pop;
    t_command                  in_cmd;
    logic [11:0]               in_index;
    logic [2*FORCE_W-1:0]      in_load;
    logic signed [POS_W-1:0]   in_x, in_y;
    logic signed [CELL_W-1:0]  xm, ym, gx, gy;
    logic [CELL_SHIFT:0]       rx, ry;

    always_comb begin
        in_cmd   = t_command'(s_axis_tuser[0]);
        in_index = s_axis_tdata[11:0];
        in_load  = {s_axis_tdata[75:44], s_axis_tdata[43:12]};
        in_x     = s_axis_tdata[91:76];
        in_y     = s_axis_tdata[107:92];
        xm       = CELL_W'(in_x) - CELL_W'(HALF);
        ym       = CELL_W'(in_y) - CELL_W'(HALF);
        gx       = xm >>> CELL_SHIFT;
        gy       = ym >>> CELL_SHIFT;
        rx       = {1'b0, xm[CELL_SHIFT-1:0]} + (CELL_SHIFT + 1)'(HALF);
        ry       = {1'b0, ym[CELL_SHIFT-1:0]} + (CELL_SHIFT + 1)'(HALF);
    end

    // Stage 1: bounds check, entry addresses, store access
    t_stage_ctl                r_s1_ctl;
    logic [11:0]               r_s1_index;
    logic [2*FORCE_W-1:0]      r_s1_load;
    logic signed [CELL_W-1:0]  r_s1_gx, r_s1_gy;
    logic [CELL_SHIFT:0]       r_s1_rx, r_s1_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl.valid   <= accept;
            r_s1_ctl.sample  <= (in_cmd == CMD_SAMPLE);
            r_s1_ctl.outside <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_index <= in_index;
        r_s1_load  <= in_load;
        r_s1_gx    <= gx;
        r_s1_gy    <= gy;
        r_s1_rx    <= rx;
        r_s1_ry    <= ry;
    end

    logic [CELL_W-1:0]    gx_p1, gy_p1;
    logic                 s1_outside;
    logic [2*DIM_W-1:0]   row_base;
    logic [IDX_W-1:0]     idx_top, idx_bot, wr_index;
    logic                 wr_en;

    always_comb begin
        gx_p1      = r_s1_gx + CELL_W'(1);
        gy_p1      = r_s1_gy + CELL_W'(1);
        s1_outside = r_s1_gx[CELL_W-1] || r_s1_gy[CELL_W-1]
                  || (gx_p1 >= CELL_W'(r_cols)) || (gy_p1 >= CELL_W'(r_rows));
        // Inside the grid both cell coordinates fit the register width.
        row_base   = r_s1_gy[DIM_W-1:0] * r_cols;
        idx_top    = IDX_W'(r_s1_gx[DIM_W-1:0]) + IDX_W'(row_base);
        idx_bot    = idx_top + IDX_W'(r_cols);
        wr_index   = IDX_W'(r_s1_index);
        wr_en      = r_s1_ctl.valid && !r_s1_ctl.sample && (wr_index < IDX_W'(GRID_DEPTH));
    end

    // Stage 2: neighbour vectors arrive from the store
    logic [2*FORCE_W-1:0]  v00, v10, v01, v11;
    t_stage_ctl            r_s2_ctl;
    logic [CELL_SHIFT:0]   r_s2_rx, r_s2_ry;

    vfbs_grid_mem #(
        .GRID_DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_index (wr_index),
        .i_wr_data  (r_s1_load),
        .i_rd_top   (idx_top),
        .i_rd_bot   (idx_bot),
        .o_v00      (v00),
        .o_v10      (v10),
        .o_v01      (v01),
        .o_v11      (v11)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl.valid   <= r_s1_ctl.valid;
            r_s2_ctl.sample  <= r_s1_ctl.sample;
            r_s2_ctl.outside <= r_s1_ctl.sample && s1_outside;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_rx <= r_s1_rx;
        r_s2_ry <= r_s1_ry;
    end

    logic     blend_push;
    t_result  blend_result, fifo_data;

    vfbs_blend #(
        .CELL_SHIFT (CELL_SHIFT)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s2_ctl),
        .i_rx     (r_s2_rx),
        .i_ry     (r_s2_ry),
        .i_v00    (v00),
        .i_v10    (v10),
        .i_v01    (v01),
        .i_v11    (v11),
        .o_push   (blend_push),
        .o_result (blend_result)
    );

    vfbs_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (blend_push),
        .i_data  (blend_result),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (fifo_data)
    );

    assign m_axis_tdata = {fifo_data.force_y, fifo_data.force_x};
    assign m_axis_tuser = fifo_data.outside_grid;

    // The pipeline never stalls, so every command taken in holds a queue slot until
    // its result transfer; counting them keeps the queue from overflowing.
    logic [USED_W-1:0] r_used;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_used < USED_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            case ({accept, pop})
                2'b10:   r_used <= r_used + USED_W'(1);
                2'b01:   r_used <= r_used - USED_W'(1);
                default: r_used <= r_used;
            endcase
        end
    end

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(FIFO_DEPTH))
        else $error("slot count exceeds queue depth");

    a_result_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_used != '0))
        else $error("result offered with no command outstanding");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_ctl.valid)
        else $error("accepted command missing from first stage");

    a_load_not_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_ctl.valid && !r_s2_ctl.sample) |-> !r_s2_ctl.outside)
        else $error("load flagged as outside the grid");

endmodule

/* tb/vector_field_bilinear_sampler_test.sv */
// Self-checking testbench of the vector field bilinear sampler: directed table, then random
// phases over several grid sizes, every result checked against the table or the predictor.
// Depends on vfbs_pkg and vector_field_bilinear_sampler.
`timescale 1ns / 100ps

module vector_field_bilinear_sampler_test;

    import vfbs_pkg::*;

    localparam int unsigned CELL_SHIFT  = 3;
    localparam int unsigned MAX_COLUMNS = 64;
    localparam int unsigned MAX_ROWS    = 64;
    localparam int unsigned GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned PHASE_ITEMS = 55;

    localparam longint CELL_ONE  = longint'(1) << CELL_SHIFT;
    localparam longint CELL_HALF = CELL_ONE / 2;
    localparam longint FORCE_MAX = 64'sd2147483647;
    localparam longint FORCE_MIN = -64'sd2147483648;

    localparam logic signed [31:0] F_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] F_MIN = 32'sh8000_0000;

    localparam t_result NO_FORCE      = '0;
    localparam t_result OUTSIDE_FORCE = t_result'({1'b1, 64'd0});

    typedef struct packed {
        t_command           cmd;
        logic [11:0]        index;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               typed;
        t_result            result;
    } t_table_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [111:0]         s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    // Mirror of the grid and the registers, updated as transfers are accepted.
    logic signed [31:0] field_x [GRID_DEPTH];
    logic signed [31:0] field_y [GRID_DEPTH];
    bit                 entry_loaded [GRID_DEPTH];
    logic [DIM_W-1:0]   grid_cols_q;
    logic [DIM_W-1:0]   grid_rows_q;

    t_result     pending_forces [$];
    int unsigned mismatches;
    bit          src_idle_on;
    bit          sink_idle_on;
    int unsigned sink_hold;

    int unsigned phase_cols [8] = '{13, 0, 127, 1, 2, 64, 40, 9};
    int unsigned phase_rows [8] = '{7, 5, 127, 2, 64, 1, 33, 0};

    vector_field_bilinear_sampler #(
        .CELL_SHIFT  (CELL_SHIFT),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint active_columns();
        return (grid_cols_q > MAX_COLUMNS) ? longint'(MAX_COLUMNS) : longint'(grid_cols_q);
    endfunction

    function automatic longint active_rows();
        return (grid_rows_q > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(grid_rows_q);
    endfunction

    // Base cell and weights of a sample; the cell is taken half a cell to the upper left.
    function automatic void locate_cell(input logic signed [15:0] px, input logic signed [15:0] py,
                                        output longint gx, output longint gy,
                                        output longint rx, output longint ry,
                                        output bit outside);
        gx = (longint'(px) - CELL_HALF) >>> CELL_SHIFT;
        gy = (longint'(py) - CELL_HALF) >>> CELL_SHIFT;
        rx = longint'(px) - gx * CELL_ONE;
        ry = longint'(py) - gy * CELL_ONE;
        outside = (gx < 0) || (gy < 0) || (gx + 1 >= active_columns()) ||
                  (gy + 1 >= active_rows());
    endfunction

    function automatic logic signed [31:0] blend_component(input longint f00, input longint f10,
                                                           input longint f01, input longint f11,
                                                           input longint rx, input longint ry);
        longint upper;
        longint lower;
        longint mixed;
        upper = (f10 * rx + f00 * (CELL_ONE - rx)) >>> CELL_SHIFT;
        lower = (f11 * rx + f01 * (CELL_ONE - rx)) >>> CELL_SHIFT;
        mixed = (lower * ry + upper * (CELL_ONE - ry)) >>> CELL_SHIFT;
        if (mixed > FORCE_MAX) begin
            mixed = FORCE_MAX;
        end else if (mixed < FORCE_MIN) begin
            mixed = FORCE_MIN;
        end
        return mixed[31:0];
    endfunction

    function automatic t_result apply_command(input t_command cmd, input logic [11:0] idx,
                                              input logic signed [31:0] lfx,
                                              input logic signed [31:0] lfy,
                                              input logic signed [15:0] px,
                                              input logic signed [15:0] py);
        t_result r;
        longint  gx, gy, rx, ry;
        int      i00, i01;
        bit      outside;
        r = NO_FORCE;
        if (cmd == CMD_LOAD) begin
            field_x[idx]      = lfx;
            field_y[idx]      = lfy;
            entry_loaded[idx] = 1'b1;
        end else begin
            locate_cell(px, py, gx, gy, rx, ry, outside);
            if (outside) begin
                r = OUTSIDE_FORCE;
            end else begin
                i00 = int'(gx + gy * active_columns());
                i01 = i00 + int'(active_columns());
                r.force_x = blend_component(field_x[i00], field_x[i00 + 1],
                                            field_x[i01], field_x[i01 + 1], rx, ry);
                r.force_y = blend_component(field_y[i00], field_y[i00 + 1],
                                            field_y[i01], field_y[i01 + 1], rx, ry);
            end
        end
        return r;
    endfunction

    function automatic t_table_row table_row(input t_command cmd, input logic [11:0] idx,
                                             input logic signed [31:0] lfx,
                                             input logic signed [31:0] lfy,
                                             input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic typed, input t_result res);
        t_table_row row;
        row.cmd    = cmd;
        row.index  = idx;
        row.load_x = lfx;
        row.load_y = lfy;
        row.pos_x  = px;
        row.pos_y  = py;
        row.typed  = typed;
        row.result = res;
        return row;
    endfunction

    // Mostly back to back, some short gaps and now and then a long one.
    function automatic int unsigned idle_length(input bit enabled);
        int unsigned roll;
        if (!enabled) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [31:0] random_force();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return F_MAX;
        end else if (roll < 8) begin
            return F_MIN;
        end else if (roll < 10) begin
            return 32'sd0;
        end else if (roll < 45) begin
            return 32'(int'($urandom_range(0, 2000)) - 1000);
        end
        return 32'($urandom);
    endfunction

    // Mostly positions over the grid and a margin around it, otherwise anywhere.
    function automatic logic signed [15:0] random_position(input longint cells);
        if ($urandom_range(0, 99) < 15) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, int'(cells) * 8 + 8)) - 4);
    endfunction

    task automatic flag_result(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %0s: expected x=%0d y=%0d outside=%0b, got x=%0d y=%0d outside=%0b",
                     $realtime, what, want.force_x, want.force_y, want.outside_grid,
                     got.force_x, got.force_y, got.outside_grid);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.force_x      = m_axis_tdata[31:0];
            got.force_y      = m_axis_tdata[63:32];
            got.outside_grid = m_axis_tuser[0];
            if (pending_forces.size() == 0) begin
                flag_result("result with nothing pending", NO_FORCE, got);
            end else begin
                want = pending_forces.pop_front();
                if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
                    got.outside_grid !== want.outside_grid) begin
                    flag_result("wrong result", want, got);
                end
            end
        end
    end

    // Receiver: ready by default, with stalls drawn after every ready cycle.
    initial begin
        m_axis_tready = 1'b0;
        sink_hold     = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (sink_hold != 0) begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_axis_tready <= 1'b1;
                sink_hold = idle_length(sink_idle_on);
            end
        end
    end

    task automatic send_command(input t_command cmd, input logic [11:0] idx,
                                input logic signed [31:0] lfx, input logic signed [31:0] lfy,
                                input logic signed [15:0] px, input logic signed [15:0] py,
                                input bit typed, input t_result typed_result);
        int unsigned gap;
        t_result     predicted;
        gap = idle_length(src_idle_on);
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, py, px, lfy, lfx, idx};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_command(cmd, idx, lfx, lfy, px, py);
        pending_forces.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_GRID_COLUMNS) begin
            grid_cols_q = value;
        end else begin
            grid_rows_q = value;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Samples that land on the grid get any missing corner loaded first, so no sample ever
    // touches an entry that has not been written since reset.
    task automatic run_random_phase(input int unsigned count, input bit pause_midway);
        t_command           cmd;
        logic signed [15:0] px, py;
        longint             gx, gy, rx, ry;
        bit                 outside;
        int                 corner [4];
        for (int unsigned n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) begin
                wait_for_results();
            end
            cmd = ($urandom_range(0, 99) < 30) ? CMD_LOAD : CMD_SAMPLE;
            px  = random_position(active_columns());
            py  = random_position(active_rows());
            if (cmd == CMD_SAMPLE) begin
                locate_cell(px, py, gx, gy, rx, ry, outside);
                if (!outside) begin
                    corner[0] = int'(gx + gy * active_columns());
                    corner[1] = corner[0] + 1;
                    corner[2] = corner[0] + int'(active_columns());
                    corner[3] = corner[2] + 1;
                    foreach (corner[k]) begin
                        if (!entry_loaded[corner[k]]) begin
                            send_command(CMD_LOAD, 12'(corner[k]), random_force(),
                                         random_force(), 16'($urandom), 16'($urandom),
                                         1'b0, NO_FORCE);
                        end
                    end
                end
            end
            send_command(cmd, 12'($urandom), random_force(), random_force(), px, py,
                         1'b0, NO_FORCE);
        end
    endtask

    initial begin
        t_table_row directed [$];
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        grid_cols_q   = DIM_W'(64);
        grid_rows_q   = DIM_W'(64);
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        mismatches    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corners of cell (0,0) with opposing extremes, so that weights beyond one saturate.
        directed.push_back(table_row(CMD_LOAD, 12'd0, F_MAX, F_MIN, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd1, F_MIN, F_MAX, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd64, F_MIN, F_MAX, 16'sh7FFF, 16'sh8000,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd65, F_MAX, F_MIN, 16'sh8000, 16'sh7FFF,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd4030, 32'sd1000, -32'sd1, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd4031, -32'sd7, 32'sd123456, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd4094, 32'sd0, F_MAX, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_LOAD, 12'd4095, F_MIN, F_MAX, 16'sd0, 16'sd0,
                                     1'b1, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'hFFF, F_MAX, F_MAX, 16'sd4, 16'sd4,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd11, 16'sd11,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd11, 16'sd4,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd4, 16'sd11,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd7, 16'sd9,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd500, 16'sd500,
                                     1'b0, NO_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd507, 16'sd507,
                                     1'b0, NO_FORCE));
        // Samples just off each edge of the grid and at the ends of the position range.
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd3, 16'sd4,
                                     1'b1, OUTSIDE_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd4, 16'sd3,
                                     1'b1, OUTSIDE_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd508, 16'sd4,
                                     1'b1, OUTSIDE_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sd4, 16'sd508,
                                     1'b1, OUTSIDE_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sh8000, 16'sh8000,
                                     1'b1, OUTSIDE_FORCE));
        directed.push_back(table_row(CMD_SAMPLE, 12'd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh7FFF,
                                     1'b1, OUTSIDE_FORCE));

        foreach (directed[k]) begin
            send_command(directed[k].cmd, directed[k].index, directed[k].load_x,
                         directed[k].load_y, directed[k].pos_x, directed[k].pos_y,
                         directed[k].typed, directed[k].result);
        end
        run_random_phase(PHASE_ITEMS, 1'b1);

        foreach (phase_cols[p]) begin
            wait_for_results();
            write_register(REG_GRID_COLUMNS, DIM_W'(phase_cols[p]));
            write_register(REG_GRID_ROWS, DIM_W'(phase_rows[p]));
            src_idle_on  = (p % 3 != 1);
            sink_idle_on = (p % 3 != 2);
            run_random_phase(PHASE_ITEMS, p % 2 == 0);
        end

        wait_for_results();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/vfbs_pkg.sv
hw/rtl/vfbs_grid_mem.sv
hw/rtl/vfbs_blend.sv
hw/rtl/vfbs_out_fifo.sv
hw/rtl/vector_field_bilinear_sampler.sv
tb/vector_field_bilinear_sampler_test.sv
